// File: rtl/core/tls_pkg.sv
package tls_pkg;

  // Width of the center tap weight register, signed Q.FRAC_BITS
  localparam int ALPHA_W = 18;

  // Sample components carried per request: x, y, z
  localparam int LANES = 3;

  // Load enables from the pipeline control to the lane datapaths
  typedef struct packed {
    logic s2_load;
    logic s3_load;
  } stage_en_t;

  function automatic int max2(input int a, input int b);
    return (a > b) ? a : b;
  endfunction

  // Signed width that holds ONE - alpha for any alpha register value
  function automatic int beta_w(input int fb);
    return max2(fb + 2, ALPHA_W) + 1;
  endfunction

endpackage

// File: rtl/core/tls_in_if.sv
interface tls_in_if #(
  parameter int SAMPLE_WIDTH = 32
);
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] sample_x;
  logic signed [SAMPLE_WIDTH-1:0] sample_y;
  logic signed [SAMPLE_WIDTH-1:0] sample_z;
  logic                           line_last;

  modport src (output valid, output sample_x, output sample_y, output sample_z,
               output line_last, input ready);
  modport snk (input valid, input sample_x, input sample_y, input sample_z,
               input line_last, output ready);
endinterface

// File: rtl/core/tls_out_if.sv
interface tls_out_if #(
  parameter int SAMPLE_WIDTH = 32
);
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] smooth_x;
  logic signed [SAMPLE_WIDTH-1:0] smooth_y;
  logic signed [SAMPLE_WIDTH-1:0] smooth_z;
  logic                           line_end;
  logic                           run_last;

  modport src (output valid, output smooth_x, output smooth_y, output smooth_z,
               output line_end, output run_last, input ready);
  modport snk (input valid, input smooth_x, input smooth_y, input smooth_z,
               input line_end, input run_last, output ready);
endinterface

// File: rtl/core/tls_lane.sv
module tls_lane import tls_pkg::*; #(
  parameter int SAMPLE_WIDTH = 32,
  parameter int FRAC_BITS    = 16
) (
  input  logic                              clk,
  input  stage_en_t                         en,
  input  logic signed [ALPHA_W-1:0]         alpha_i,
  input  logic signed [beta_w(FRAC_BITS)-1:0] beta_i,
  input  logic signed [SAMPLE_WIDTH-1:0]    c_i,
  input  logic signed [SAMPLE_WIDTH:0]      lr_i,
  output logic signed [SAMPLE_WIDTH-1:0]    res_o
);

  localparam int SW    = SAMPLE_WIDTH;
  localparam int FB    = FRAC_BITS;
  localparam int BW    = beta_w(FB);
  localparam int PW_A  = ALPHA_W + SW;
  localparam int PW_B  = BW + SW + 1;
  localparam int ACC_W = max2(max2(PW_A + 1, PW_B), SW + FB + 1) + 1;
  localparam int QW    = ACC_W - FB - 1;

  localparam logic signed [ACC_W-1:0] ONE_ACC = {{(ACC_W-1){1'b0}}, 1'b1} << FB;
  localparam logic signed [QW-1:0]    Q_MAX   = QW'({1'b0, {(SW-1){1'b1}}});
  localparam logic signed [QW-1:0]    Q_MIN   = ~Q_MAX;

  logic signed [PW_A-1:0]  p_ac_r;
  logic signed [PW_B-1:0]  p_bl_r;
  logic signed [ACC_W-1:0] acc;
  logic signed [QW-1:0]    q;
  logic signed [SW-1:0]    res_nxt;
  logic signed [SW-1:0]    res_r;

  // center and side products
  always_ff @(posedge clk) begin
    if (en.s2_load) begin
      p_ac_r <= PW_A'(alpha_i) * PW_A'(c_i);
      p_bl_r <= PW_B'(beta_i) * PW_B'(lr_i);
    end
  end

  // 2*a*c + beta*(l+r), round half up, drop FB+1 fraction bits
  assign acc = (ACC_W'(p_ac_r) <<< 1) + ACC_W'(p_bl_r) + ONE_ACC;
  assign q   = acc[ACC_W-1:FB+1];

  // clamp to the sample range
  always_comb begin
    if (q > Q_MAX) begin
      res_nxt = {1'b0, {(SW-1){1'b1}}};
    end else if (q < Q_MIN) begin
      res_nxt = {1'b1, {(SW-1){1'b0}}};
    end else begin
      res_nxt = q[SW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en.s3_load) begin
      res_r <= res_nxt;
    end
  end

  assign res_o = res_r;

endmodule

// File: rtl/core/three_tap_line_smoother.sv
// Pipeline: a request passes through the operand regs (loaded at accept), then the product
//   and result regs, before its result is valid.
// Throughput: one request per cycle while results are not stalled. The last sample of a line
//   longer than one sample yields two results and holds off the next request until the second is issued.
// A stalled result does not block intake until the three pipeline stages are full.
// Reset (rst_n, synchronous, active low): pipeline empty, no sample held, alpha = 1.0.
module three_tap_line_smoother import tls_pkg::*; #(
  parameter int SAMPLE_WIDTH = 32,
  parameter int FRAC_BITS    = 16
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic signed [ALPHA_W-1:0] cfg_wdata,
  tls_in_if.snk                     in_smp,
  tls_out_if.src                    out_res
);

  localparam int SW = SAMPLE_WIDTH;
  localparam int BW = beta_w(FRAC_BITS);

  localparam logic signed [BW-1:0]      ONE_B     = {{(BW-1){1'b0}}, 1'b1} << FRAC_BITS;
  localparam logic signed [ALPHA_W-1:0] ALPHA_RST = ALPHA_W'(ONE_B);
  localparam logic signed [BW-1:0]      BETA_RST  = ONE_B - BW'(ALPHA_RST);

  // configuration
  logic signed [ALPHA_W-1:0] alpha_r;
  logic signed [BW-1:0]      beta_r;

  // line state
  logic              holding_r, holding_nxt;
  logic              tail_pend_r, tail_pend_nxt;
  logic signed [SW-1:0] left_r [LANES];
  logic signed [SW-1:0] held_r [LANES];
  logic signed [SW-1:0] left_nxt [LANES];
  logic signed [SW-1:0] smp [LANES];

  // operand stage
  logic              req_vld_r, req_vld_nxt;
  logic              req_ld;
  logic              req_end_r, req_end_nxt;
  logic              req_last_r, req_last_nxt;
  logic signed [SW-1:0] req_c_r [LANES];
  logic signed [SW:0]   req_lr_r [LANES];
  logic signed [SW-1:0] req_c_nxt [LANES];
  logic signed [SW:0]   req_lr_nxt [LANES];

  // product and result stages
  logic              s2_vld_r, s2_end_r, s2_last_r;
  logic              out_vld_r, out_end_r, out_last_r;
  logic signed [SW-1:0] res [LANES];

  logic              s3_free, s2_free, s1_free, in_acc;
  stage_en_t         en;

  assign smp[0] = in_smp.sample_x;
  assign smp[1] = in_smp.sample_y;
  assign smp[2] = in_smp.sample_z;

  // stage advance, each stage moves when the next one is free
  assign s3_free    = !out_vld_r || out_res.ready;
  assign s2_free    = !s2_vld_r || s3_free;
  assign s1_free    = !req_vld_r || s2_free;
  assign en.s3_load = s2_vld_r && s3_free;
  assign en.s2_load = req_vld_r && s2_free;

  assign in_smp.ready = s1_free && !tail_pend_r;
  assign in_acc       = in_smp.valid && in_smp.ready;

  // request formation from the held sample and its neighbors
  always_comb begin
    holding_nxt   = holding_r;
    tail_pend_nxt = tail_pend_r;
    req_vld_nxt   = req_vld_r;
    req_ld        = 1'b0;
    req_end_nxt   = 1'b0;
    req_last_nxt  = 1'b0;
    for (int i = 0; i < LANES; i++) begin
      left_nxt[i]   = left_r[i];
      req_c_nxt[i]  = held_r[i];
      req_lr_nxt[i] = (SW+1)'(left_r[i]);
    end
    if (tail_pend_r && s1_free) begin
      // second result of a line end: right neighbor is zero
      tail_pend_nxt = 1'b0;
      req_vld_nxt   = 1'b1;
      req_ld        = 1'b1;
      req_end_nxt   = 1'b1;
      req_last_nxt  = 1'b1;
    end else if (in_acc) begin
      for (int i = 0; i < LANES; i++) begin
        left_nxt[i] = holding_r ? held_r[i] : '0;
      end
      req_ld      = 1'b1;
      req_vld_nxt = holding_r || in_smp.line_last;
      if (holding_r) begin
        for (int i = 0; i < LANES; i++) begin
          req_lr_nxt[i] = (SW+1)'(left_r[i]) + (SW+1)'(smp[i]);
        end
        req_last_nxt = !in_smp.line_last;
      end else begin
        // one-sample line: both neighbors are zero
        for (int i = 0; i < LANES; i++) begin
          req_c_nxt[i]  = smp[i];
          req_lr_nxt[i] = '0;
        end
        req_end_nxt  = 1'b1;
        req_last_nxt = 1'b1;
      end
      tail_pend_nxt = in_smp.line_last && holding_r;
      holding_nxt   = !in_smp.line_last;
    end else if (s1_free) begin
      req_vld_nxt = 1'b0;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alpha_r     <= ALPHA_RST;
      beta_r      <= BETA_RST;
      holding_r   <= 1'b0;
      tail_pend_r <= 1'b0;
      req_vld_r   <= 1'b0;
      s2_vld_r    <= 1'b0;
      out_vld_r   <= 1'b0;
    end else begin
      if (cfg_we) begin
        alpha_r <= cfg_wdata;
        beta_r  <= ONE_B - BW'(cfg_wdata);
      end
      holding_r   <= holding_nxt;
      tail_pend_r <= tail_pend_nxt;
      req_vld_r   <= req_vld_nxt;
      if (s2_free) begin
        s2_vld_r <= req_vld_r;
      end
      if (s3_free) begin
        out_vld_r <= s2_vld_r;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      for (int i = 0; i < LANES; i++) begin
        left_r[i] <= left_nxt[i];
        held_r[i] <= smp[i];
      end
    end
    if (req_ld) begin
      req_end_r  <= req_end_nxt;
      req_last_r <= req_last_nxt;
      for (int i = 0; i < LANES; i++) begin
        req_c_r[i]  <= req_c_nxt[i];
        req_lr_r[i] <= req_lr_nxt[i];
      end
    end
    if (en.s2_load) begin
      s2_end_r  <= req_end_r;
      s2_last_r <= req_last_r;
    end
    if (en.s3_load) begin
      out_end_r  <= s2_end_r;
      out_last_r <= s2_last_r;
    end
  end

  // per-component datapaths
  for (genvar g = 0; g < LANES; g++) begin : g_lane
    tls_lane #(
      .SAMPLE_WIDTH (SAMPLE_WIDTH),
      .FRAC_BITS    (FRAC_BITS)
    ) u_lane (
      .clk     (clk),
      .en      (en),
      .alpha_i (alpha_r),
      .beta_i  (beta_r),
      .c_i     (req_c_r[g]),
      .lr_i    (req_lr_r[g]),
      .res_o   (res[g])
    );
  end

  assign out_res.valid    = out_vld_r;
  assign out_res.smooth_x = res[0];
  assign out_res.smooth_y = res[1];
  assign out_res.smooth_z = res[2];
  assign out_res.line_end = out_end_r;
  assign out_res.run_last = out_last_r;

`ifndef SYNTHESIS
  // a line-end result always closes the run of its request
  a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && out_end_r |-> out_last_r)
    else $error("line_end result without run_last");

  // a pending second result means the line is already forgotten
  a_tail_not_holding: assert property (@(posedge clk) disable iff (!rst_n)
    !(tail_pend_r && holding_r))
    else $error("tail pending while a sample is held");

  // last sample of a longer line schedules a second result
  a_tail_follows: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_smp.line_last && holding_r |=> tail_pend_r && req_vld_r)
    else $error("missing tail request after line end");

  // a stalled result is not dropped
  a_out_held: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && !out_res.ready |=> out_vld_r)
    else $error("stalled result lost");
`endif

endmodule

// File: tb/testbench.sv
module testbench;
  import tls_pkg::*;

  localparam int SW = 32;
  localparam int FB = 16;
  localparam longint ONE_Q = longint'(1) << FB;
  localparam longint SAT_HI = (longint'(1) << (SW - 1)) - 1;
  localparam longint SAT_LO = -SAT_HI - 1;
  localparam int STALL_LIMIT = 1000;
  localparam int HOLD_CYCLES = 150;
  localparam int SETTLE_CYCLES = 8;
  localparam int PHASE_ITEMS = 220;
  localparam logic [SW-1:0] S_MAX = 32'h7fff_ffff;
  localparam logic [SW-1:0] S_MIN = 32'h8000_0000;

  typedef logic [LANES-1:0][SW-1:0] triple_t;

  typedef struct packed {
    triple_t lane;
    logic    line_end;
    logic    run_last;
  } smooth_res_t;

  // Line smoother model plus the queue of smoothed samples still owed by the block
  class smooth_scoreboard;
    logic signed [ALPHA_W-1:0] alpha = 65536;
    longint left_nb[LANES];
    longint held[LANES];
    bit holding;
    smooth_res_t pending[$];
    int errors;
    int checked;
    int lines;

    // alpha * c + beta * (l + r) / 2, rounded half up, saturated
    function logic [SW-1:0] tap(longint l, longint c, longint r);
      longint a, acc, q;
      a = alpha;
      acc = 2 * a * c + (ONE_Q - a) * (l + r) + ONE_Q;
      q = acc >>> (FB + 1);
      if (q > SAT_HI) q = SAT_HI;
      else if (q < SAT_LO) q = SAT_LO;
      return q[SW-1:0];
    endfunction

    function smooth_res_t make_result(triple_t s, bit use_right, bit end_f, bit last_f);
      smooth_res_t res;
      for (int i = 0; i < LANES; i++) begin
        res.lane[i] = tap(left_nb[i], held[i], use_right ? longint'($signed(s[i])) : 0);
      end
      res.line_end = end_f;
      res.run_last = last_f;
      return res;
    endfunction

    // Accepted request: queue the results it releases
    function void note_sample(triple_t s, bit is_last);
      if (holding) begin
        pending.push_back(make_result(s, 1'b1, 1'b0, !is_last));
        for (int i = 0; i < LANES; i++) left_nb[i] = held[i];
      end else begin
        for (int i = 0; i < LANES; i++) left_nb[i] = 0;
      end
      for (int i = 0; i < LANES; i++) held[i] = $signed(s[i]);
      holding = 1'b1;
      if (is_last) begin
        pending.push_back(make_result(s, 1'b0, 1'b1, 1'b1));
        for (int i = 0; i < LANES; i++) begin
          left_nb[i] = 0;
          held[i] = 0;
        end
        holding = 1'b0;
        lines++;
      end
    endfunction

    function void report(string field, logic [SW-1:0] exp_v, logic [SW-1:0] got_v);
      errors++;
      $display("%0t: %s mismatch, expected %h actual %h", $time, field, exp_v, got_v);
    endfunction

    // Accepted result: compare with the oldest expectation
    function void check_result(smooth_res_t got);
      smooth_res_t exp_r;
      checked++;
      if (pending.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none actual %h", $time, got);
        return;
      end
      exp_r = pending.pop_front();
      if (exp_r.lane[0] !== got.lane[0]) report("smooth_x", exp_r.lane[0], got.lane[0]);
      if (exp_r.lane[1] !== got.lane[1]) report("smooth_y", exp_r.lane[1], got.lane[1]);
      if (exp_r.lane[2] !== got.lane[2]) report("smooth_z", exp_r.lane[2], got.lane[2]);
      if (exp_r.line_end !== got.line_end) report("line_end", exp_r.line_end, got.line_end);
      if (exp_r.run_last !== got.run_last) report("run_last", exp_r.run_last, got.run_last);
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic signed [ALPHA_W-1:0] cfg_wdata;

  tls_in_if #(.SAMPLE_WIDTH(SW)) smp_if ();
  tls_out_if #(.SAMPLE_WIDTH(SW)) res_if ();

  three_tap_line_smoother #(
    .SAMPLE_WIDTH(SW),
    .FRAC_BITS   (FB)
  ) uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_smp   (smp_if),
    .out_res  (res_if)
  );

  smooth_scoreboard sb;
  int in_count = 0;
  int in_idle_pct = 30;
  int out_idle_pct = 30;
  int alpha_settings = 0;
  int stall_cycles = 0;

  // Clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Result monitor
  always @(posedge clk) begin : result_mon
    smooth_res_t got;
    if (rst_n === 1'b1 && res_if.valid && res_if.ready) begin
      got.lane[0] = res_if.smooth_x;
      got.lane[1] = res_if.smooth_y;
      got.lane[2] = res_if.smooth_z;
      got.line_end = res_if.line_end;
      got.run_last = res_if.run_last;
      sb.check_result(got);
    end
  end

  // Watchdog: no request moving on either side for too long
  always @(posedge clk) begin
    if ((smp_if.valid && smp_if.ready) || (res_if.valid && res_if.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("Stalled for %0d cycles at %0t", stall_cycles, $time);
      $display("TEST FAILED");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // Result side: random back-pressure, plus long hold-offs to fill the pipeline
  initial begin : receiver
    int hold_left;
    int next_hold;
    int hold_at[2];
    hold_left = 0;
    next_hold = 0;
    hold_at[0] = 500;
    hold_at[1] = 1200;
    res_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        res_if.ready = 1'b0;
        hold_left--;
      end else if (next_hold < 2 && in_count >= hold_at[next_hold]) begin
        next_hold++;
        hold_left = HOLD_CYCLES;
        res_if.ready = 1'b0;
      end else begin
        res_if.ready = ($urandom_range(99) >= out_idle_pct);
      end
    end
  end

  // Offer one sample, with random gaps; returns at the falling edge after acceptance
  task automatic send_sample(input logic [SW-1:0] x, input logic [SW-1:0] y,
                             input logic [SW-1:0] z, input bit is_last);
    while ($urandom_range(99) < in_idle_pct) begin
      smp_if.valid = 1'b0;
      @(negedge clk);
    end
    smp_if.valid = 1'b1;
    smp_if.sample_x = x;
    smp_if.sample_y = y;
    smp_if.sample_z = z;
    smp_if.line_last = is_last;
    do @(posedge clk); while (!smp_if.ready);
    sb.note_sample({z, y, x}, is_last);
    in_count++;
    @(negedge clk);
  endtask

  function automatic logic [SW-1:0] rand_sample();
    int pick;
    pick = $urandom_range(99);
    if (pick < 10) begin
      case ($urandom_range(4))
        0: return S_MAX;
        1: return S_MIN;
        2: return '0;
        3: return '1;
        default: return 32'h0000_0001;
      endcase
    end else if (pick < 40) begin
      return 32'($urandom_range(0, 32'h001f_ffff)) - 32'h0010_0000;
    end
    return $urandom();
  endfunction

  task automatic send_line(input int len);
    for (int k = 0; k < len; k++) begin
      send_sample(rand_sample(), rand_sample(), rand_sample(), k == len - 1);
    end
  endtask

  // Wait for every owed result, then let the pipeline settle
  task automatic drain();
    smp_if.valid = 1'b0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic set_alpha(input int v);
    cfg_wdata = v[ALPHA_W-1:0];
    cfg_we = 1'b1;
    @(negedge clk);
    cfg_we = 1'b0;
    sb.alpha = cfg_wdata;
    alpha_settings++;
  endtask

  initial begin : stimulus
    int target;
    int len_pick;
    int phase_alpha[8];
    sb = new();
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    smp_if.valid = 1'b0;
    smp_if.sample_x = '0;
    smp_if.sample_y = '0;
    smp_if.sample_z = '0;
    smp_if.line_last = 1'b0;
    repeat (10) @(negedge clk);
    rst_n = 1'b1;

    // Identity from reset: a one-sample line, then a two-sample line
    send_sample(S_MAX, S_MIN, '0, 1'b1);
    send_sample(S_MIN, S_MAX, 32'h0001_8000, 1'b0);
    send_sample(32'h1234_5678, '1, 32'h0000_0001, 1'b1);
    drain();

    // Half weight: rounding ties of both signs, then a plain line
    set_alpha(32768);
    send_sample(32'h0000_0001, '1, 32'h0000_0003, 1'b1);
    send_sample(32'h0001_0000, 32'hfffe_0000, 32'h0000_0005, 1'b0);
    send_sample(32'h0003_0000, 32'h0002_0000, 32'hffff_fffb, 1'b0);
    send_sample(32'hfff0_0000, 32'h7fff_0000, 32'h0000_0007, 1'b1);
    drain();

    // Centre weight above one: opposite extremes saturate both ways
    set_alpha(72089);
    send_sample(S_MIN, S_MAX, '0, 1'b0);
    send_sample(S_MAX, S_MIN, '0, 1'b0);
    send_sample(S_MIN, S_MAX, '0, 1'b1);
    drain();

    // Most negative register value
    set_alpha(-131072);
    send_sample(S_MAX, S_MIN, 32'h0000_0001, 1'b0);
    send_sample(S_MAX, S_MIN, '1, 1'b0);
    send_sample(S_MAX, S_MIN, 32'h0000_0001, 1'b1);
    drain();

    // Most positive register value
    set_alpha(131071);
    send_sample(S_MAX, 32'h0000_ffff, S_MIN, 1'b0);
    send_sample(S_MIN, 32'hffff_0001, S_MAX, 1'b1);
    drain();

    // Zero centre weight: plain neighbour average
    set_alpha(0);
    send_sample(32'h0004_0000, S_MAX, S_MIN, 1'b0);
    send_sample(32'h7777_7777, S_MAX, S_MIN, 1'b0);
    send_sample(32'hfffc_0000, S_MAX, S_MIN, 1'b1);
    drain();

    set_alpha(-6553);
    send_sample(S_MAX, 32'h0000_8000, S_MIN, 1'b0);
    send_sample(S_MAX, 32'hffff_8000, S_MIN, 1'b1);
    drain();

    // Random lines, one alpha per phase
    phase_alpha[0] = $urandom_range(0, 78642) - 6553;
    phase_alpha[1] = 65536;
    phase_alpha[2] = $urandom_range(0, 78642) - 6553;
    phase_alpha[3] = 0;
    phase_alpha[4] = 72089;
    phase_alpha[5] = -6553;
    phase_alpha[6] = -131072;
    phase_alpha[7] = $urandom_range(0, 262143);
    for (int p = 0; p < 8; p++) begin
      set_alpha(phase_alpha[p]);
      in_idle_pct = (p == 2) ? 0 : 30;
      out_idle_pct = (p == 2) ? 0 : 30;
      target = in_count + PHASE_ITEMS;
      while (in_count < target) begin
        len_pick = $urandom_range(99);
        if (len_pick < 15) send_line(1);
        else if (len_pick < 85) send_line($urandom_range(2, 8));
        else send_line($urandom_range(9, 40));
      end
      drain();
    end

    $display("Covered %0d samples in %0d lines, %0d smoothed results checked,",
             in_count, sb.lines, sb.checked);
    $display("under %0d alpha settings from -2.0 to just under 2.0.", alpha_settings);
    if (sb.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d mismatches", sb.errors);
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
